// ===== hdl/lcg_random_with_shuffle_table_defines.svh =====
// Assertion macros shared by the RTL files.
`ifndef LCG_RANDOM_WITH_SHUFFLE_TABLE_DEFINES_SVH
`define LCG_RANDOM_WITH_SHUFFLE_TABLE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define LRS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define LRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lrs_pkg.sv =====
package lrs_pkg;

    localparam int unsigned TableEntriesDefault = 256;
    localparam logic [15:0] LcgMul = 16'd25173;
    localparam logic [15:0] LcgAdd = 16'd13849;
    localparam logic [15:0] FullRange = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_SEED    = 2'd0,
        OP_RANDOM  = 2'd1,
        OP_SHUFFLE = 2'd2,
        OP_QUICK   = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRAW_MUL,
        ST_DRAW_DIV,
        ST_DRAW_DONE,
        ST_CLEAR,
        ST_FILL,
        ST_SH_MUL,
        ST_SH_DIV,
        ST_SH_RD,
        ST_SH_WR_I,
        ST_SH_WR_J,
        ST_QUICK_RD,
        ST_QUICK_OUT
    } t_state;

    typedef struct packed {
        logic seed_load;
        logic max_load;
        logic lcg_step;
        logic div_start;
        logic out_random;
        logic out_zero;
        logic out_table;
        logic clr_step;
        logic fill_step;
        logic fill_init;
        logic sh_load_i;
        logic sh_rd;
        logic sh_wr_i;
        logic sh_wr_j;
        logic sh_dec;
        logic q_rd;
        logic q_adv;
        logic ptr_clear;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic clr_last;
        logic fill_last;
        logic sh_last;
    } t_status;

endpackage

// ===== hdl/lrs_datapath.sv =====
module lrs_datapath #(
    parameter int unsigned TABLE_ENTRIES = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [15:0]    i_seed_value,
    input  logic [15:0]    i_max,
    input  lrs_pkg::t_cmd  i_cmd,
    output lrs_pkg::t_status o_status,
    output logic [15:0]    o_value
);
    import lrs_pkg::*;
    `include "lcg_random_with_shuffle_table_defines.svh"

    localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [AW-1:0] LastIdx = AW'(TABLE_ENTRIES - 1);

    logic [15:0]   r_lcg, n_lcg;
    logic [AW-1:0] r_ptr, w_addr, r_i, r_j;
    logic [7:0]    r_ti, r_tj;
    logic [7:0]    r_mem [TABLE_ENTRIES];
    logic [7:0]    r_rdata;
    logic [15:0]   r_value;
    logic [15:0]   r_max;
    logic [15:0]   r_rem, r_quo_sh;
    logic [16:0]   r_div;
    logic [4:0]    r_cnt;
    logic          r_div_busy;
    logic [16:0]   n_trial;
    logic [16:0]   n_rem_sh;
    logic [15:0]   w_rem_fin;
    logic [7:0]    w_wdata;

    // One product per cycle; the draw rule then reduces it bit by bit.
    assign n_lcg = 16'(r_lcg * LcgMul + LcgAdd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcg <= 16'd1;
        end else if (i_cmd.seed_load) begin
            r_lcg <= i_seed_value | 16'd1;
        end else if (i_cmd.lcg_step) begin
            r_lcg <= n_lcg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sh_load_i) begin
            r_max <= 16'(r_i);
        end else if (i_cmd.max_load) begin
            r_max <= i_max;
        end
    end

    assign n_rem_sh  = {r_rem, r_quo_sh[15]};
    assign n_trial   = n_rem_sh - r_div;
    assign w_rem_fin = n_trial[16] ? n_rem_sh[15:0] : n_trial[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_cnt      <= '0;
        end else if (i_cmd.div_start) begin
            r_div_busy <= 1'b1;
            r_cnt      <= 5'd16;
            r_rem      <= '0;
            r_quo_sh   <= r_lcg;
            r_div      <= {1'b0, r_max} + 17'd1;
        end else if (r_div_busy) begin
            r_quo_sh <= {r_quo_sh[14:0], 1'b0};
            r_rem    <= w_rem_fin;
            r_cnt    <= r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                r_div_busy <= 1'b0;
            end
        end
    end

    assign o_status.div_done = r_div_busy && (r_cnt == 5'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
        end else if (i_cmd.fill_init) begin
            r_i <= LastIdx;
        end else if (i_cmd.clr_step || i_cmd.fill_step) begin
            r_i <= (r_i == LastIdx) ? '0 : r_i + AW'(1);
        end else if (i_cmd.sh_dec) begin
            r_i <= r_i - AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_status.div_done) begin
            r_j <= AW'(({1'b0, w_rem_fin[7:0]} >= 9'(TABLE_ENTRIES)) ? 8'd0 : w_rem_fin[7:0]);
        end
    end

    assign o_status.clr_last  = (r_i == LastIdx);
    assign o_status.fill_last = (r_i == LastIdx);
    assign o_status.sh_last   = (r_i == AW'(1));

    always_comb begin
        w_addr  = r_i;
        w_wdata = '0;
        if (i_cmd.fill_step) begin
            w_wdata = 8'(r_i);
        end else if (i_cmd.sh_wr_i) begin
            w_wdata = r_tj;
        end else if (i_cmd.sh_wr_j) begin
            w_addr  = r_j;
            w_wdata = r_ti;
        end else if (i_cmd.sh_rd) begin
            w_addr = r_j;
        end else if (i_cmd.q_rd) begin
            w_addr = r_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step || i_cmd.fill_step || i_cmd.sh_wr_i || i_cmd.sh_wr_j) begin
            r_mem[w_addr] <= w_wdata;
        end
        r_rdata <= r_mem[w_addr];
    end

    // Entry i is read in the multiply step, entry j in the read step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sh_load_i) begin
            r_ti <= r_mem[w_addr];
        end
        if (i_cmd.sh_rd) begin
            r_tj <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.ptr_clear) begin
            r_ptr <= '0;
        end else if (i_cmd.q_adv) begin
            r_ptr <= (r_ptr == LastIdx) ? '0 : r_ptr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_zero) begin
            r_value <= '0;
        end else if (i_cmd.out_table) begin
            r_value <= {8'd0, r_rdata};
        end else if (i_cmd.out_random) begin
            if (r_max == 16'd0) begin
                r_value <= '0;
            end else if (r_max == FullRange) begin
                r_value <= r_lcg;
            end else begin
                r_value <= r_rem;
            end
        end
    end

    assign o_value = r_value;

    `LRS_ASSERT_NEXT(a_div_len, i_clk, i_rst_n, i_cmd.div_start, r_div_busy && r_cnt == 5'd16, "divider did not start")
    `LRS_ASSERT_IMPL(a_rem_lt, i_clk, i_rst_n, !r_div_busy && r_cnt == 5'd0 && r_div != 17'd0 && $past(r_div_busy), {1'b0, r_rem} < r_div, "remainder not below divisor")
    `LRS_ASSERT_IMPL(a_lcg_odd_seed, i_clk, i_rst_n, $past(i_cmd.seed_load) && $past(i_rst_n), r_lcg[0], "seeded state is even")
endmodule

// ===== hdl/lrs_ctrl.sv =====
module lrs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic [1:0]       i_op,
    input  lrs_pkg::t_status i_status,
    output lrs_pkg::t_cmd    o_cmd,
    output logic             busy,
    output logic             o_strobe
);
    import lrs_pkg::*;
    `include "lcg_random_with_shuffle_table_defines.svh"

    t_state r_state, n_state;
    logic   r_strobe, n_strobe;
    logic   r_cleared;
    logic   r_div_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_strobe    <= 1'b0;
            r_cleared   <= 1'b0;
            r_div_first <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_strobe    <= n_strobe;
            r_div_first <= (r_state == ST_DRAW_MUL) || (r_state == ST_SH_MUL);
            if (r_state == ST_CLEAR && i_status.clr_last) begin
                r_cleared <= 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    unique case (t_op'(i_op))
                        OP_SEED:    n_state = ST_IDLE;
                        OP_RANDOM:  n_state = ST_DRAW_MUL;
                        OP_SHUFFLE: n_state = ST_FILL;
                        OP_QUICK:   n_state = ST_QUICK_RD;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_DRAW_MUL:  n_state = ST_DRAW_DIV;
            ST_DRAW_DIV:  n_state = i_status.div_done ? ST_DRAW_DONE : ST_DRAW_DIV;
            ST_DRAW_DONE: n_state = ST_IDLE;
            ST_CLEAR:     n_state = i_status.clr_last ? ST_IDLE : ST_CLEAR;
            ST_FILL:      n_state = i_status.fill_last ? ST_SH_MUL : ST_FILL;
            ST_SH_MUL:    n_state = ST_SH_DIV;
            ST_SH_DIV:    n_state = i_status.div_done ? ST_SH_RD : ST_SH_DIV;
            ST_SH_RD:     n_state = ST_SH_WR_I;
            ST_SH_WR_I:   n_state = ST_SH_WR_J;
            ST_SH_WR_J:   n_state = i_status.sh_last ? ST_IDLE : ST_SH_MUL;
            ST_QUICK_RD:  n_state = ST_QUICK_OUT;
            ST_QUICK_OUT: n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd    = '0;
        n_strobe = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.seed_load = (t_op'(i_op) == OP_SEED);
                    o_cmd.out_zero  = (t_op'(i_op) == OP_SEED);
                    n_strobe        = (t_op'(i_op) == OP_SEED);
                    o_cmd.max_load  = (t_op'(i_op) == OP_RANDOM);
                end
            end
            ST_DRAW_MUL: begin
                o_cmd.lcg_step = 1'b1;
            end
            ST_DRAW_DIV: begin
                o_cmd.div_start = r_div_first;
            end
            ST_DRAW_DONE: begin
                o_cmd.out_random = 1'b1;
                n_strobe         = 1'b1;
            end
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            ST_FILL: begin
                o_cmd.fill_step = 1'b1;
                o_cmd.fill_init = i_status.fill_last;
            end
            ST_SH_MUL: begin
                o_cmd.sh_load_i = 1'b1;
                o_cmd.lcg_step  = 1'b1;
            end
            ST_SH_DIV: begin
                o_cmd.div_start = r_div_first;
            end
            ST_SH_RD: begin
                o_cmd.sh_rd = 1'b1;
            end
            ST_SH_WR_I: begin
                o_cmd.sh_wr_i = 1'b1;
            end
            ST_SH_WR_J: begin
                o_cmd.sh_wr_j = 1'b1;
                o_cmd.sh_dec  = 1'b1;
                if (i_status.sh_last) begin
                    o_cmd.ptr_clear = 1'b1;
                    o_cmd.out_zero  = 1'b1;
                    n_strobe        = 1'b1;
                end
            end
            ST_QUICK_RD: begin
                o_cmd.q_rd  = 1'b1;
                o_cmd.q_adv = 1'b1;
            end
            ST_QUICK_OUT: begin
                o_cmd.out_table = 1'b1;
                n_strobe        = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;

    `LRS_ASSERT_NEXT(a_seed_strobe, i_clk, i_rst_n, r_state == ST_IDLE && start && i_op == OP_SEED, o_strobe, "seed gave no result")
    `LRS_ASSERT_IMPL(a_strobe_idle, i_clk, i_rst_n, o_strobe && !$past(r_state == ST_IDLE), r_state == ST_IDLE, "result while still busy")
    `LRS_ASSERT_IMPL(a_clear_first, i_clk, i_rst_n, r_state == ST_FILL, r_cleared, "table used before clearing")
endmodule

// ===== hdl/lcg_random_with_shuffle_table.sv =====
// Seed: result in the cycle after the transfer. Random: one multiply step, then the
// bit-serial remainder unit. Shuffle: a fill pass, then one swap per entry, one table port.
// Quick random: a registered table read, then the output. One item at a time.
// After reset the table is cleared entry by entry with busy high.
// The receiver cannot stall; o_strobe marks each result for one cycle.
module lcg_random_with_shuffle_table #(
    parameter int unsigned TABLE_ENTRIES = lrs_pkg::TableEntriesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_seed_value,
    input  logic [15:0] i_max,
    output logic        o_strobe,
    output logic [15:0] o_value
);
    import lrs_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    lrs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_op     (i_op),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .busy     (busy),
        .o_strobe (o_strobe)
    );

    lrs_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed_value (i_seed_value),
        .i_max        (i_max),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_value      (o_value)
    );
endmodule

// ===== tb/lcg_random_with_shuffle_table_tb.sv =====
module lcg_random_with_shuffle_table_tb;
    import lrs_pkg::*;

    typedef struct {
        t_op         op;
        logic [15:0] seed_value;
        logic [15:0] max;
    } t_command;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_op;
    logic [15:0] i_seed_value;
    logic [15:0] i_max;
    logic        o_strobe;
    logic [15:0] o_value;

    t_command    pending_cmds[$];
    logic [15:0] expected_values[$];

    logic [15:0] lcg_state;
    logic [7:0]  shuffle_table[256];
    logic [7:0]  read_pointer;

    int  errors = 0;
    int  sent = 0;
    int  received = 0;
    int  shuffles = 0;
    int  idle_cycles = 0;
    int  gap_left = 0;
    int  burst_left = 0;
    bit  stim_done = 0;

    lcg_random_with_shuffle_table i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_op(i_op),
        .i_seed_value(i_seed_value),
        .i_max(i_max),
        .o_strobe(o_strobe),
        .o_value(o_value)
    );

    function automatic logic [15:0] lcg_draw(input logic [15:0] max);
        logic [31:0] s;
        s = (32'(lcg_state) * 32'(LcgMul) + 32'(LcgAdd)) & 32'hFFFF;
        lcg_state = s[15:0];
        if (max == 16'd0) return 16'd0;
        if (max == FullRange) return lcg_state;
        return 16'(s % (32'(max) + 32'd1));
    endfunction

    function automatic void shuffle_bytes();
        logic [7:0] t;
        int j;
        for (int i = 0; i < 256; i++) shuffle_table[i] = 8'(i);
        for (int i = 255; i > 0; i--) begin
            j = int'(lcg_draw(16'(i)) & 16'h00FF);
            t = shuffle_table[i];
            shuffle_table[i] = shuffle_table[j];
            shuffle_table[j] = t;
        end
        read_pointer = 8'd0;
    endfunction

    function automatic logic [15:0] predict_value(input t_command c);
        logic [15:0] v;
        v = 16'd0;
        case (c.op)
            OP_SEED: lcg_state = c.seed_value | 16'd1;
            OP_RANDOM: v = lcg_draw(c.max);
            OP_SHUFFLE: shuffle_bytes();
            default: begin
                v = {8'd0, shuffle_table[read_pointer]};
                read_pointer = read_pointer + 8'd1;
            end
        endcase
        return v;
    endfunction

    task automatic add_cmd(input t_op op, input logic [15:0] sv, input logic [15:0] mx);
        t_command c;
        c.op = op;
        c.seed_value = sv;
        c.max = mx;
        pending_cmds.push_back(c);
    endtask

    function automatic logic [15:0] random_max();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return FullRange;
            2: return 16'($urandom_range(1, 20));
            3: return 16'(1 << $urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        t_op op;
        int r;
        i_rst_n = 0;
        lcg_state = 16'd1;
        read_pointer = 8'd0;
        foreach (shuffle_table[k]) shuffle_table[k] = 8'd0;
        add_cmd(OP_QUICK, 16'hFFFF, 16'hFFFF);
        add_cmd(OP_QUICK, 16'h0000, 16'h0000);
        add_cmd(OP_RANDOM, 16'h0000, 16'd0);
        add_cmd(OP_RANDOM, 16'h0000, 16'hFFFF);
        add_cmd(OP_RANDOM, 16'hFFFF, 16'hFFFE);
        add_cmd(OP_RANDOM, 16'h0000, 16'd1);
        add_cmd(OP_SEED, 16'h0000, 16'hFFFF);
        add_cmd(OP_RANDOM, 16'h0000, 16'd6);
        add_cmd(OP_SEED, 16'hFFFF, 16'h0000);
        add_cmd(OP_RANDOM, 16'h0000, 16'h8000);
        add_cmd(OP_SEED, 16'h1234, 16'h5555);
        add_cmd(OP_SHUFFLE, 16'hAAAA, 16'h5555);
        for (int k = 0; k < 258; k++) add_cmd(OP_QUICK, 16'($urandom), 16'($urandom));
        add_cmd(OP_RANDOM, 16'h0000, 16'd255);
        for (int k = 0; k < 1680; k++) begin
            r = $urandom_range(0, 99);
            if (r < 10) op = OP_SEED;
            else if (r < 50) op = OP_RANDOM;
            else if (r < 51) op = OP_SHUFFLE;
            else op = OP_QUICK;
            add_cmd(op, 16'($urandom), random_max());
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_op <= OP_SEED;
            i_seed_value <= 16'd0;
            i_max <= 16'd0;
        end else if (!(start && busy)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                start <= 1'b1;
                i_op <= pending_cmds[0].op;
                i_seed_value <= pending_cmds[0].seed_value;
                i_max <= pending_cmds[0].max;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            expected_values.push_back(predict_value(pending_cmds.pop_front()));
            sent <= sent + 1;
            if (i_op == OP_SHUFFLE) shuffles <= shuffles + 1;
            if (burst_left > 0) begin
                burst_left <= burst_left - 1;
            end else begin
                burst_left <= $urandom_range(0, 12);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
            idle_cycles <= 0;
        end else if (o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (i_rst_n && o_strobe) begin
            received <= received + 1;
            if (expected_values.size() == 0) begin
                $display("%0t: result %h with no transfer pending", $time, o_value);
                errors++;
            end else begin
                logic [15:0] exp_v;
                exp_v = expected_values.pop_front();
                if (o_value !== exp_v) begin
                    $display("%0t: value mismatch expected %h actual %h",
                             $time, exp_v, o_value);
                    errors++;
                end
            end
        end
    end

    initial begin
        wait (i_rst_n);
        fork
            begin
                wait (pending_cmds.size() == 0 && expected_values.size() == 0);
                repeat (50) @(posedge i_clk);
            end
            wait (idle_cycles >= 20000);
        join_any
        $display("Sent %0d commands including %0d table shuffles, checked %0d results.",
                 sent, shuffles, received);
        if (idle_cycles >= 20000 || expected_values.size() != 0 || errors != 0) begin
            $display("simulation failed");
        end else begin
            $display("simulation ok");
        end
        $finish;
    end
endmodule
